// File: rtl/xxtea_pkg.sv
// shared types, constants and helper functions of the xxtea block cipher
package xxtea_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam int WORD_W        = 32;
  localparam int ROUND_W       = 6;
  localparam int LEN_W         = 7;
  localparam int CFG_IDX_W     = 3;

  localparam logic [WORD_W-1:0] XX_DELTA  = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] KEY_RESET = 32'hAFAC_E0FF;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEED_ACC,
    ST_SEED_X,
    ST_SEED_NB,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // 6 + 52/n for block lengths of two words and up
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [LEN_W-1:0] n);
    logic [ROUND_W-1:0] r;
    if (n <= 7'd2)       r = 6'd32;
    else if (n == 7'd3)  r = 6'd23;
    else if (n == 7'd4)  r = 6'd19;
    else if (n == 7'd5)  r = 6'd16;
    else if (n == 7'd6)  r = 6'd14;
    else if (n == 7'd7)  r = 6'd13;
    else if (n == 7'd8)  r = 6'd12;
    else if (n <= 7'd10) r = 6'd11;
    else if (n <= 7'd13) r = 6'd10;
    else if (n <= 7'd17) r = 6'd9;
    else if (n <= 7'd26) r = 6'd8;
    else if (n <= 7'd52) r = 6'd7;
    else                 r = 6'd6;
    return r;
  endfunction

endpackage

// File: rtl/xxtea_ram.sv
// generic single-write, single-read ram with registered read data
module xxtea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/xxtea_block_cipher.sv
// xxtea block cipher top level: word store, mixing loop and result drain
//
//  channel | direction | payload
//  s_*     | in        | tdata data_word, tlast last_word, tuser command
//  m_*     | out       | tdata result_word, tlast result_last, tuser length_error
//  cfg_*   | in        | cfg_index register, cfg_data value (key words 0..3)
//
// a block of n >= 2 words is loaded, seeded and mixed for (6 + 52/n) rounds of n
// steps, then drained; the mixing loop does one step a cycle, bound by the single
// read port of the word store, and the drain waits for each read to return.
// reset clears the fsm and counters, presets the keys; the store needs no clearing.
// a stalled result holds the drain; input is taken only while loading.
module xxtea_block_cipher #(
  parameter int MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [xxtea_pkg::WORD_W-1:0]    s_tdata,   // data_word
  input  logic                            s_tlast,
  input  logic                            s_tuser,   // command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [xxtea_pkg::WORD_W-1:0]    m_tdata,   // result_word
  output logic                            m_tlast,
  output logic                            m_tuser,   // length_error
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xxtea_pkg::WORD_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(MAX_WORDS);
  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int W     = xxtea_pkg::WORD_W;
  localparam int RW    = xxtea_pkg::ROUND_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORDS);

  xxtea_pkg::state_t state, state_next;

  logic [W-1:0]     key [4];
  logic [CNT_W-1:0] word_count;
  logic             overflow;
  logic             decrypt_mode;
  logic [CNT_W-1:0] blk_len;
  logic             blk_err;
  logic [IDX_W-1:0] p;
  logic [W-1:0]     acc;
  logic [W-1:0]     xw;
  logic [W-1:0]     round_sum;
  logic [RW-1:0]    rounds_left;
  logic             fwd_hit;
  logic [W-1:0]     fwd_data;
  logic [IDX_W-1:0] drain_idx;
  logic             rd_pend;
  logic             rd_last;
  logic             rd_err;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [W-1:0]     wdata;
  logic [IDX_W-1:0] raddr;
  logic [W-1:0]     rdata;

  logic             load_fire;
  logic             load_store;
  logic [CNT_W-1:0] new_len;
  logic [CNT_W-1:0] len_m1;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] p_next;
  logic [IDX_W-1:0] p_after;
  logic             round_end;
  logic             drain_issue;
  logic [W-1:0]     nb;
  logic [W-1:0]     mz;
  logic [W-1:0]     my;
  logic [1:0]       kidx;
  logic [W-1:0]     mix_a;
  logic [W-1:0]     mix_b;
  logic [W-1:0]     mix;
  logic [W-1:0]     new_word;

  function automatic logic [IDX_W-1:0] step_next(input logic [IDX_W-1:0] i,
                                                 input logic dec,
                                                 input logic [IDX_W-1:0] last);
    logic [IDX_W-1:0] r;
    if (dec) begin
      r = (i == '0) ? last : i - IDX_W'(1);
    end else begin
      r = (i == last) ? '0 : i + IDX_W'(1);
    end
    return r;
  endfunction

  xxtea_ram #(
    .WIDTH (W),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_ready  = 1'b1;
  assign load_fire  = s_tvalid && s_tready;
  assign load_store = load_fire && (word_count < MAX_CNT);
  assign new_len    = load_store ? word_count + CNT_W'(1) : word_count;
  assign len_m1     = blk_len - CNT_W'(1);
  assign last_idx   = len_m1[IDX_W-1:0];
  assign p_next     = step_next(p, decrypt_mode, last_idx);
  assign p_after    = step_next(p_next, decrypt_mode, last_idx);
  assign round_end  = (p == (decrypt_mode ? '0 : last_idx));

  // one mixing step
  assign nb       = fwd_hit ? fwd_data : rdata;
  assign mz       = decrypt_mode ? nb : acc;
  assign my       = decrypt_mode ? acc : nb;
  assign kidx     = 2'(p) ^ round_sum[3:2];
  assign mix_a    = ((mz >> 5) ^ (my << 2)) + ((my >> 3) ^ (mz << 4));
  assign mix_b    = (round_sum ^ my) + (key[kidx] ^ mz);
  assign mix      = mix_a ^ mix_b;
  assign new_word = decrypt_mode ? xw - mix : xw + mix;

  always_comb begin
    state_next = state;
    unique case (state)
      xxtea_pkg::ST_LOAD: begin
        if (load_fire && s_tlast) begin
          state_next = (new_len < CNT_W'(2)) ? xxtea_pkg::ST_DRAIN : xxtea_pkg::ST_SEED_ACC;
        end
      end
      xxtea_pkg::ST_SEED_ACC: state_next = xxtea_pkg::ST_SEED_X;
      xxtea_pkg::ST_SEED_X:   state_next = xxtea_pkg::ST_SEED_NB;
      xxtea_pkg::ST_SEED_NB:  state_next = xxtea_pkg::ST_RUN;
      xxtea_pkg::ST_RUN: begin
        if (round_end && rounds_left == RW'(1)) begin
          state_next = xxtea_pkg::ST_DRAIN;
        end
      end
      xxtea_pkg::ST_DRAIN: begin
        if (drain_issue && drain_idx == last_idx) begin
          state_next = xxtea_pkg::ST_LOAD;
        end
      end
      default: state_next = xxtea_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    we          = 1'b0;
    waddr       = p;
    wdata       = new_word;
    raddr       = p_after;
    drain_issue = 1'b0;
    unique case (state)
      xxtea_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        we       = load_store;
        waddr    = word_count[IDX_W-1:0];
        wdata    = s_tdata;
      end
      xxtea_pkg::ST_SEED_ACC: raddr = decrypt_mode ? '0 : last_idx;
      xxtea_pkg::ST_SEED_X:   raddr = p;
      xxtea_pkg::ST_SEED_NB:  raddr = p_next;
      xxtea_pkg::ST_RUN: begin
        we    = 1'b1;
        raddr = p_after;
      end
      xxtea_pkg::ST_DRAIN: begin
        raddr       = drain_idx;
        drain_issue = !rd_pend && (!m_tvalid || m_tready);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= xxtea_pkg::ST_LOAD;
      key[0]       <= xxtea_pkg::KEY_RESET;
      key[1]       <= xxtea_pkg::KEY_RESET;
      key[2]       <= xxtea_pkg::KEY_RESET;
      key[3]       <= xxtea_pkg::KEY_RESET;
      word_count   <= '0;
      overflow     <= 1'b0;
      decrypt_mode <= 1'b0;
      blk_len      <= '0;
      blk_err      <= 1'b0;
      rounds_left  <= '0;
      drain_idx    <= '0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          xxtea_pkg::REG_KEY0: key[0] <= cfg_data;
          xxtea_pkg::REG_KEY1: key[1] <= cfg_data;
          xxtea_pkg::REG_KEY2: key[2] <= cfg_data;
          xxtea_pkg::REG_KEY3: key[3] <= cfg_data;
          default: begin
          end
        endcase
      end

      if (load_fire) begin
        if (word_count == '0 && !overflow) begin
          decrypt_mode <= s_tuser;
        end
        if (s_tlast) begin
          blk_len    <= new_len;
          blk_err    <= (new_len < CNT_W'(2)) || overflow || !load_store;
          word_count <= '0;
          overflow   <= 1'b0;
        end else if (load_store) begin
          word_count <= new_len;
        end else begin
          overflow <= 1'b1;
        end
      end

      if (state == xxtea_pkg::ST_SEED_ACC) begin
        rounds_left <= xxtea_pkg::rounds_for(xxtea_pkg::LEN_W'(blk_len));
      end else if (state == xxtea_pkg::ST_RUN && round_end) begin
        rounds_left <= rounds_left - RW'(1);
      end

      if (state != xxtea_pkg::ST_DRAIN) begin
        drain_idx <= '0;
      end else if (drain_issue) begin
        drain_idx <= drain_idx + IDX_W'(1);
      end
      rd_pend <= drain_issue;

      if (rd_pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_hit  <= we && (waddr == raddr);
    fwd_data <= wdata;

    unique case (state)
      xxtea_pkg::ST_SEED_ACC: begin
        p         <= decrypt_mode ? last_idx : '0;
        round_sum <= xxtea_pkg::XX_DELTA;
      end
      xxtea_pkg::ST_SEED_X: begin
        acc <= rdata;
        if (decrypt_mode) begin
          round_sum <= W'(rounds_left) * xxtea_pkg::XX_DELTA;
        end
      end
      xxtea_pkg::ST_SEED_NB: begin
        xw <= rdata;
      end
      xxtea_pkg::ST_RUN: begin
        acc <= new_word;
        xw  <= nb;
        p   <= p_next;
        if (round_end) begin
          round_sum <= decrypt_mode ? round_sum - xxtea_pkg::XX_DELTA
                                    : round_sum + xxtea_pkg::XX_DELTA;
        end
      end
      default: begin
      end
    endcase

    if (drain_issue) begin
      rd_last <= (drain_idx == last_idx);
      rd_err  <= blk_err;
    end
    if (rd_pend) begin
      m_tdata <= rdata;
      m_tlast <= rd_last;
      m_tuser <= rd_err;
    end
  end

endmodule

// File: rtl/xxtea_chk.sv
// port-level checker for the xxtea block cipher, bound to the top level
module xxtea_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  logic in_frame;
  logic frame_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      frame_err <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      in_frame <= !m_tlast;
      if (!in_frame) begin
        frame_err <= m_tuser;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after the last word of a block");

  a_err_per_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && in_frame |-> m_tuser == frame_err)
    else $error("length error flag changed within a block");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind xxtea_block_cipher xxtea_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: verif/xxtea_checker.sv
// checker for the xxtea block cipher: tracks keys and blocks, predicts and compares results
module xxtea_checker #(
  parameter int MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [xxtea_pkg::WORD_W-1:0]    s_tdata,   // data_word
  input  logic                            s_tlast,
  input  logic                            s_tuser,   // command
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [xxtea_pkg::WORD_W-1:0]    m_tdata,   // result_word
  input  logic                            m_tlast,
  input  logic                            m_tuser,   // length_error
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xxtea_pkg::WORD_W-1:0]    cfg_data,
  output int                              mismatches,
  output int                              awaited,
  output int                              words_checked
);
  import xxtea_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              err;
  } cipher_word_t;

  cipher_word_t      cipher_out_q[$];
  logic [WORD_W-1:0] key[4];
  logic [WORD_W-1:0] blk[MAX_WORDS];
  int unsigned       fill;
  bit                spilled;
  bit                decrypting;

  function automatic logic [WORD_W-1:0] mx(logic [WORD_W-1:0] z, logic [WORD_W-1:0] y,
                                           logic [WORD_W-1:0] sum, int unsigned p,
                                           logic [1:0] e);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [1:0]        ki;
    ki = p[1:0] ^ e;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (key[ki] ^ z);
    return a ^ b;
  endfunction

  function automatic void encipher(int unsigned n);
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
    logic [1:0]        e;
    int unsigned       rounds;
    int unsigned       p;
    rounds = 6 + 52 / n;
    sum = '0;
    z = blk[n-1];
    repeat (rounds) begin
      sum += XX_DELTA;
      e = sum[3:2];
      for (p = 0; p + 1 < n; p++) begin
        blk[p] += mx(z, blk[p+1], sum, p, e);
        z = blk[p];
      end
      blk[n-1] += mx(z, blk[0], sum, n - 1, e);
      z = blk[n-1];
    end
  endfunction

  function automatic void decipher(int unsigned n);
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] sum;
    logic [1:0]        e;
    int unsigned       rounds;
    int unsigned       p;
    rounds = 6 + 52 / n;
    sum = rounds * XX_DELTA;
    y = blk[0];
    repeat (rounds) begin
      e = sum[3:2];
      for (p = n - 1; p > 0; p--) begin
        z = blk[p-1];
        blk[p] -= mx(z, y, sum, p, e);
        y = blk[p];
      end
      z = blk[n-1];
      blk[0] -= mx(z, y, sum, 0, e);
      y = blk[0];
      sum -= XX_DELTA;
    end
  endfunction

  function automatic void store_word(logic cmd, logic [WORD_W-1:0] w, logic last);
    cipher_word_t r;
    int unsigned  k;
    if (fill == 0 && !spilled) decrypting = cmd;
    if (fill < MAX_WORDS) begin
      blk[fill] = w;
      fill++;
    end else begin
      spilled = 1'b1;
    end
    if (last) begin
      if (fill >= 2) begin
        if (decrypting) decipher(fill);
        else encipher(fill);
      end
      for (k = 0; k < fill; k++) begin
        r.word = blk[k];
        r.last = (k + 1 == fill);
        r.err  = (fill < 2) || spilled;
        cipher_out_q.push_back(r);
      end
      fill = 0;
      spilled = 1'b0;
    end
  endfunction

  function automatic void check_word(logic [WORD_W-1:0] w, logic last, logic err);
    cipher_word_t want;
    if (cipher_out_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: word %h last %b err %b", w, last, err);
    end else begin
      want = cipher_out_q.pop_front();
      if (want.word !== w || want.last !== last || want.err !== err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected word %h last %b err %b, got word %h last %b err %b",
                   words_checked, want.word, want.last, want.err, w, last, err);
      end
    end
    words_checked++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key[i] = KEY_RESET;
      fill = 0;
      spilled = 1'b0;
      decrypting = 1'b0;
      mismatches = 0;
      words_checked = 0;
      cipher_out_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0: key[0] = cfg_data;
          REG_KEY1: key[1] = cfg_data;
          REG_KEY2: key[2] = cfg_data;
          REG_KEY3: key[3] = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) store_word(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_word(m_tdata, m_tlast, m_tuser);
    end
    awaited = cipher_out_q.size();
  end

endmodule

// File: verif/tb_xxtea_block_cipher.sv
// testbench top for the xxtea block cipher: clock, reset, key writes, block stimulus, verdict
module tb_xxtea_block_cipher;
  import xxtea_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [WORD_W-1:0]    s_tdata;   // data_word
  logic                 s_tlast;
  logic                 s_tuser;   // command
  logic                 m_tvalid;
  logic                 m_tready;
  logic [WORD_W-1:0]    m_tdata;   // result_word
  logic                 m_tlast;
  logic                 m_tuser;   // length_error
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  int mismatches;
  int awaited;
  int words_checked;

  logic [WORD_W-1:0] blk_words[0:69];
  bit                gaps_on;
  int                stall_left;
  int                blocks_sent;
  int                words_sent;
  int                phase_words;
  int                key_sets;

  xxtea_block_cipher uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  xxtea_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaited(awaited), .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d result words outstanding", awaited);
    $display("status: fail");
    $finish;
  end

  // result side back-pressure
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (gaps_on && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 5);
      m_tready = !rst && (stall_left == 0);
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_keys(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1,
                           logic [WORD_W-1:0] k2, logic [WORD_W-1:0] k3);
    write_key(REG_KEY0, k0);
    write_key(REG_KEY1, k1);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY3, k3);
    cfg_valid = 1'b0;
    key_sets++;
  endtask

  task automatic hold_off();
    int n;
    n = $urandom_range(1, 5);
    s_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // sends blk_words[0..n-1]; only the first word's command counts
  task automatic send_block(logic cmd, int n);
    for (int i = 0; i < n; i++) begin
      if (gaps_on && $urandom_range(0, 3) == 0) hold_off();
      s_tvalid = 1'b1;
      s_tdata  = blk_words[i];
      s_tlast  = (i == n - 1);
      s_tuser  = (i == 0) ? cmd : 1'($urandom_range(0, 1));
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
      words_sent++;
      phase_words++;
    end
    blocks_sent++;
  endtask

  task automatic send_random_block(int n);
    for (int i = 0; i < n; i++) blk_words[i] = pick_word();
    send_block(1'($urandom_range(0, 1)), n);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 1;
    else if (r <= 14) return $urandom_range(2, 6);
    else if (r <= 17) return $urandom_range(7, 16);
    else return $urandom_range(17, 30);
  endfunction

  task automatic drain_out();
    s_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY0;
    cfg_data = '0;
    gaps_on = 1'b0;
    blocks_sent = 0;
    words_sent = 0;
    key_sets = 1;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed blocks under the reset key
    gaps_on = 1'b1;
    blk_words[0] = '0;
    blk_words[1] = '1;
    send_block(1'b0, 2);
    blk_words[0] = '1;
    blk_words[1] = '0;
    send_block(1'b1, 2);
    // single word blocks come back flagged
    blk_words[0] = 32'h8000_0001;
    send_block(1'b0, 1);
    blk_words[0] = 32'h7FFF_FFFE;
    send_block(1'b1, 1);
    for (int i = 0; i < 4; i++) blk_words[i] = '0;
    send_block(1'b0, 4);
    send_random_block(3);
    send_random_block(5);
    drain_out();

    for (int phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: load_keys('0, '0, '0, '0);
        2: load_keys('1, '1, '1, '1);
        3: load_keys($urandom, '0, '1, $urandom);
        default: load_keys($urandom, $urandom, $urandom, $urandom);
      endcase
      phase_words = 0;
      gaps_on = (phase != 4);
      // full store, then store overflow with dropped words
      if (phase == 2) begin
        for (int i = 0; i < MAX_WORDS_DEF; i++) blk_words[i] = pick_word();
        send_block(1'($urandom_range(0, 1)), MAX_WORDS_DEF);
      end
      if (phase == 3) send_random_block(MAX_WORDS_DEF + $urandom_range(1, 2));
      while (phase_words < 40 + ((phase == 2 || phase == 3) ? 65 : 0)) begin
        if (phase != 4) gaps_on = ($urandom_range(0, 3) != 0);
        send_random_block(pick_length());
      end
      drain_out();
    end

    repeat (20) @(negedge clk);
    $display("run covered %0d blocks, %0d words in, %0d words out, %0d key settings",
             blocks_sent, words_sent, words_checked, key_sets);
    $display("blocks of 1 to 66 words, encrypt and decrypt, full and overflowed store");
    if (mismatches == 0 && awaited == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d result words outstanding", mismatches, awaited);
      $display("status: fail");
    end
    $finish;
  end

endmodule
